// ===== rtl/wsd_pkg.sv =====
// Shared types, constants and helpers for the WAV stream to float decoder.
// Used by every module of the block; depends on nothing else.
package wsd_pkg;

    // Output queue depth, a power of two of at least eight.
    localparam int FIFO_DEPTH = 8;

    // Chunk and header tags as seen after four bytes shifted in from the top.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Index of the last byte of the part of the fmt chunk that is kept.
    localparam logic [4:0] FMT_BODY_LAST = 5'd15;

    // Stream status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_RIFF    = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE    = 3'd2;
    localparam logic [2:0] ST_INCOMPLETE  = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    // Encoding codes from the fmt chunk.
    localparam logic [15:0] FMT_PCM   = 16'd1;
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_ID    = 4'd3,
        PH_SIZE  = 4'd4,
        PH_FMT   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_DATA  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // How the raw sample word turns into a float.
    typedef enum logic [1:0] {
        CVT_PCM16 = 2'd0,
        CVT_PCM24 = 2'd1,
        CVT_PCM32 = 2'd2,
        CVT_FLOAT = 2'd3
    } cvt_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] sample_value;
        logic [15:0] channel_index;
        logic [31:0] rate_hz;
        logic [15:0] channel_total;
        logic [15:0] sample_width;
        logic [31:0] data_length;
        logic [2:0]  status;
        logic        final_res;
    } res_t;

    // Up to two results caused by one input beat; slot0 is filled first.
    typedef struct packed {
        logic [1:0] valid;
        cvt_t       cvt;
        res_t       slot0;
        res_t       slot1;
    } pair_t;

    // Replace byte pos of a little-endian word.
    function automatic logic [31:0] set_byte(input logic [31:0] word,
                                             input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = word;
        r[pos*8 +: 8] = b;
        return r;
    endfunction

endpackage

// ===== rtl/wsd_parser.sv =====
// Header and chunk parser of the WAV decoder: walks the byte stream and
// registers up to two raw results per byte. Depends on wsd_pkg.
module wsd_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    output wsd_pkg::pair_t     out_pair
);

    wsd_pkg::phase_t ph_reg, ph_next;
    logic [4:0]  ubc_reg, ubc_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] clen_reg, clen_next;
    logic [32:0] skip_reg, skip_next;
    logic [15:0] fmtc_reg, fmtc_next;
    logic [15:0] chn_reg, chn_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] balign_reg, balign_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;
    logic [31:0] room_reg, room_next;
    logic [15:0] chpos_reg, chpos_next;
    logic [31:0] asm_reg, asm_next;
    logic [1:0]  sbi_reg, sbi_next;
    logic [2:0]  st_reg, st_next;
    logic [15:0] fbyte_reg, fbyte_next;
    wsd_pkg::pair_t pair_reg, pair_next;

    // Result candidates of the current byte.
    logic           have_a, have_b, have_c;
    wsd_pkg::res_t  res_a, res_b, res_c;
    wsd_pkg::cvt_t  cvt_a;

    // Next state of the parser for one accepted byte.
    always_comb
    begin
        logic [3:0]  fi;
        logic [2:0]  bps;
        logic [15:0] cp;
        logic [1:0]  sbi;
        logic [31:0] asm_w;
        logic [16:0] f1;
        logic [16:0] reach;
        logic [32:0] sk;
        logic [2:0]  st_eos;
        ph_next     = ph_reg;
        ubc_next    = ubc_reg;
        tag_next    = tag_reg;
        clen_next   = clen_reg;
        skip_next   = skip_reg;
        fmtc_next   = fmtc_reg;
        chn_next    = chn_reg;
        rate_next   = rate_reg;
        balign_next = balign_reg;
        bits_next   = bits_reg;
        seen_next   = seen_reg;
        room_next   = room_reg;
        chpos_next  = chpos_reg;
        asm_next    = asm_reg;
        sbi_next    = sbi_reg;
        st_next     = st_reg;
        fbyte_next  = fbyte_reg;
        have_a = 1'b0;
        have_b = 1'b0;
        have_c = 1'b0;
        res_a  = '0;
        res_b  = '0;
        res_c  = '0;
        cvt_a  = wsd_pkg::CVT_PCM16;
        fi     = ubc_reg[3:0];
        bps    = bits_reg[5:3];
        cp     = chpos_reg;
        sbi    = sbi_reg;
        asm_w  = asm_reg;
        f1     = {1'b0, fbyte_reg} + 17'd1;
        reach  = '0;
        sk     = '0;
        st_eos = wsd_pkg::ST_INCOMPLETE;

        unique case (ph_reg)
            wsd_pkg::PH_RIFF, wsd_pkg::PH_RSIZE, wsd_pkg::PH_WAVE, wsd_pkg::PH_ID:
            begin
                tag_next = {in_byte, tag_reg[31:8]};
                ubc_next = ubc_reg + 5'd1;
                if (ubc_reg >= 5'd3)
                begin
                    ubc_next = '0;
                    unique case (ph_reg)
                        wsd_pkg::PH_RIFF:
                        begin
                            if (tag_next != wsd_pkg::TAG_RIFF)
                            begin
                                have_a       = 1'b1;
                                res_a.kind   = wsd_pkg::KIND_ERROR;
                                res_a.status = wsd_pkg::ST_NOT_RIFF;
                                st_next      = wsd_pkg::ST_NOT_RIFF;
                                ph_next      = wsd_pkg::PH_DONE;
                            end
                            else
                            begin
                                ph_next = wsd_pkg::PH_RSIZE;
                            end
                        end
                        wsd_pkg::PH_RSIZE: ph_next = wsd_pkg::PH_WAVE;
                        wsd_pkg::PH_WAVE:
                        begin
                            if (tag_next != wsd_pkg::TAG_WAVE)
                            begin
                                have_a       = 1'b1;
                                res_a.kind   = wsd_pkg::KIND_ERROR;
                                res_a.status = wsd_pkg::ST_NOT_WAVE;
                                st_next      = wsd_pkg::ST_NOT_WAVE;
                                ph_next      = wsd_pkg::PH_DONE;
                            end
                            else
                            begin
                                ph_next = wsd_pkg::PH_ID;
                            end
                        end
                        default: ph_next = wsd_pkg::PH_SIZE;
                    endcase
                end
            end

            wsd_pkg::PH_SIZE:
            begin
                clen_next = wsd_pkg::set_byte(clen_reg, ubc_reg[1:0], in_byte);
                ubc_next  = ubc_reg + 5'd1;
                if (ubc_reg >= 5'd3)
                begin
                    ubc_next = '0;
                    if (tag_reg == wsd_pkg::TAG_FMT)
                    begin
                        ph_next = wsd_pkg::PH_FMT;
                    end
                    else if (tag_reg == wsd_pkg::TAG_DATA)
                    begin
                        // Data chunk header: report the format or fail.
                        have_a = 1'b1;
                        if (!seen_reg || chn_reg == '0 || rate_reg == '0 || balign_reg == '0)
                        begin
                            res_a.kind   = wsd_pkg::KIND_ERROR;
                            res_a.status = wsd_pkg::ST_INCOMPLETE;
                            st_next      = wsd_pkg::ST_INCOMPLETE;
                            ph_next      = wsd_pkg::PH_DONE;
                        end
                        else if (!((fmtc_reg == wsd_pkg::FMT_PCM && (bits_reg == 16'd16 ||
                                    bits_reg == 16'd24 || bits_reg == 16'd32)) ||
                                   (fmtc_reg == wsd_pkg::FMT_FLOAT && bits_reg == 16'd32)))
                        begin
                            res_a.kind   = wsd_pkg::KIND_ERROR;
                            res_a.status = wsd_pkg::ST_UNSUPPORTED;
                            st_next      = wsd_pkg::ST_UNSUPPORTED;
                            ph_next      = wsd_pkg::PH_DONE;
                        end
                        else
                        begin
                            res_a.kind          = wsd_pkg::KIND_FORMAT;
                            res_a.rate_hz       = rate_reg;
                            res_a.channel_total = chn_reg;
                            res_a.sample_width  = bits_reg;
                            res_a.data_length   = clen_next;
                            room_next  = clen_next;
                            fbyte_next = '0;
                            ph_next    = (clen_next == '0) ? wsd_pkg::PH_DONE : wsd_pkg::PH_DATA;
                        end
                    end
                    else
                    begin
                        sk        = {1'b0, clen_next} + {32'd0, clen_next[0]};
                        skip_next = sk;
                        ph_next   = (sk == '0) ? wsd_pkg::PH_ID : wsd_pkg::PH_SKIP;
                    end
                end
            end

            wsd_pkg::PH_FMT:
            begin
                unique case (fi)
                    4'd0, 4'd1:
                        fmtc_next = 16'(wsd_pkg::set_byte({16'd0, fmtc_reg}, {1'b0, fi[0]},
                                                          in_byte));
                    4'd2, 4'd3:
                        chn_next = 16'(wsd_pkg::set_byte({16'd0, chn_reg}, {1'b0, fi[0]},
                                                         in_byte));
                    4'd4, 4'd5, 4'd6, 4'd7:
                        rate_next = wsd_pkg::set_byte(rate_reg, fi[1:0], in_byte);
                    4'd12, 4'd13:
                        balign_next = 16'(wsd_pkg::set_byte({16'd0, balign_reg},
                                                            {1'b0, fi[0]}, in_byte));
                    4'd14, 4'd15:
                        bits_next = 16'(wsd_pkg::set_byte({16'd0, bits_reg}, {1'b0, fi[0]},
                                                          in_byte));
                    default: ;
                endcase
                ubc_next = {1'b0, fi} + 5'd1;
                if ({1'b0, fi} == wsd_pkg::FMT_BODY_LAST)
                begin
                    ubc_next  = '0;
                    seen_next = 1'b1;
                    sk = ((clen_reg > 32'd16) ? {1'b0, clen_reg - 32'd16} : 33'd0)
                         + {32'd0, clen_reg[0]};
                    skip_next = sk;
                    ph_next   = (sk == '0) ? wsd_pkg::PH_ID : wsd_pkg::PH_SKIP;
                end
            end

            wsd_pkg::PH_SKIP:
            begin
                sk        = (skip_reg != '0) ? skip_reg - 33'd1 : skip_reg;
                skip_next = sk;
                if (sk == '0)
                    ph_next = wsd_pkg::PH_ID;
            end

            wsd_pkg::PH_DATA:
            begin
                if (fbyte_reg == '0 && room_reg < {16'd0, balign_reg})
                begin
                    // Trailing partial frame: drop the rest of the chunk.
                    ph_next = wsd_pkg::PH_DONE;
                end
                else
                begin
                    if (fbyte_reg == '0)
                    begin
                        cp  = '0;
                        sbi = '0;
                    end
                    chpos_next = cp;
                    sbi_next   = sbi;
                    reach = {1'b0, fbyte_reg} + {14'd0, bps - {1'b0, sbi}};
                    if (cp < chn_reg && reach <= {1'b0, balign_reg})
                    begin
                        asm_w = wsd_pkg::set_byte(asm_reg, sbi, in_byte);
                        if ({1'b0, sbi} + 3'd1 >= bps)
                        begin
                            have_a              = 1'b1;
                            res_a.kind          = wsd_pkg::KIND_SAMPLE;
                            res_a.sample_value  = asm_w;
                            res_a.channel_index = cp;
                            chpos_next = cp + 16'd1;
                            sbi_next   = '0;
                            asm_next   = '0;
                        end
                        else
                        begin
                            sbi_next = sbi + 2'd1;
                            asm_next = asm_w;
                        end
                    end
                    fbyte_next = (f1 >= {1'b0, balign_reg}) ? 16'd0 : f1[15:0];
                    room_next  = room_reg - 32'd1;
                    if (room_next == '0)
                        ph_next = wsd_pkg::PH_DONE;
                end
            end

            default: ;
        endcase

        // Conversion kind of a sample.
        if (fmtc_reg == wsd_pkg::FMT_FLOAT)
            cvt_a = wsd_pkg::CVT_FLOAT;
        else if (bits_reg == 16'd16)
            cvt_a = wsd_pkg::CVT_PCM16;
        else if (bits_reg == 16'd24)
            cvt_a = wsd_pkg::CVT_PCM24;
        else
            cvt_a = wsd_pkg::CVT_PCM32;

        // Last byte of the file: close out and rearm.
        if (in_last)
        begin
            if (ph_next < wsd_pkg::PH_DATA)
            begin
                if (ph_next == wsd_pkg::PH_RIFF)
                    st_eos = wsd_pkg::ST_NOT_RIFF;
                else if (ph_next == wsd_pkg::PH_WAVE)
                    st_eos = wsd_pkg::ST_NOT_WAVE;
                have_b       = 1'b1;
                res_b.kind   = wsd_pkg::KIND_ERROR;
                res_b.status = st_eos;
                st_next      = st_eos;
            end
            have_c       = 1'b1;
            res_c.kind   = wsd_pkg::KIND_END;
            res_c.status = st_next;
            ph_next     = wsd_pkg::PH_RIFF;
            ubc_next    = '0;
            tag_next    = '0;
            clen_next   = '0;
            skip_next   = '0;
            fmtc_next   = '0;
            chn_next    = '0;
            rate_next   = '0;
            balign_next = '0;
            bits_next   = '0;
            seen_next   = 1'b0;
            room_next   = '0;
            chpos_next  = '0;
            asm_next    = '0;
            sbi_next    = '0;
            st_next     = '0;
            fbyte_next  = '0;
        end
    end

    // Pack the candidates into slots, first result in slot0.
    always_comb
    begin
        pair_next                 = '0;
        pair_next.cvt             = cvt_a;
        pair_next.valid[0]        = in_valid && (have_a || have_b || have_c);
        pair_next.valid[1]        = in_valid && (have_a || have_b) && have_c;
        if (have_a)
            pair_next.slot0 = res_a;
        else if (have_b)
            pair_next.slot0 = res_b;
        else
            pair_next.slot0 = res_c;
        pair_next.slot1           = res_c;
        pair_next.slot0.final_res = !((have_a || have_b) && have_c);
        pair_next.slot1.final_res = 1'b1;
    end

    // Parser state, updated on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= wsd_pkg::PH_RIFF;
            ubc_reg    <= '0;
            tag_reg    <= '0;
            clen_reg   <= '0;
            skip_reg   <= '0;
            fmtc_reg   <= '0;
            chn_reg    <= '0;
            rate_reg   <= '0;
            balign_reg <= '0;
            bits_reg   <= '0;
            seen_reg   <= 1'b0;
            room_reg   <= '0;
            chpos_reg  <= '0;
            asm_reg    <= '0;
            sbi_reg    <= '0;
            st_reg     <= '0;
            fbyte_reg  <= '0;
        end
        else if (in_valid)
        begin
            ph_reg     <= ph_next;
            ubc_reg    <= ubc_next;
            tag_reg    <= tag_next;
            clen_reg   <= clen_next;
            skip_reg   <= skip_next;
            fmtc_reg   <= fmtc_next;
            chn_reg    <= chn_next;
            rate_reg   <= rate_next;
            balign_reg <= balign_next;
            bits_reg   <= bits_next;
            seen_reg   <= seen_next;
            room_reg   <= room_next;
            chpos_reg  <= chpos_next;
            asm_reg    <= asm_next;
            sbi_reg    <= sbi_next;
            st_reg     <= st_next;
            fbyte_reg  <= fbyte_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_reg <= '0;
        else
            pair_reg <= pair_next;
    end

    assign out_pair = pair_reg;

endmodule

// ===== rtl/wsd_to_float.sv =====
// Two-stage conversion of a raw sample word to an IEEE single bit pattern:
// leading-one search, then normalize and round. Depends on wsd_pkg.
module wsd_to_float (
    input  logic           clk,
    input  logic           rst_n,
    input  wsd_pkg::pair_t in_pair,
    output wsd_pkg::pair_t out_pair
);

    wsd_pkg::pair_t pair_reg;
    logic [31:0]    mag_reg, mag_next;
    logic [4:0]     top_reg, top_next;
    logic           neg_reg, neg_next;

    // Stage one: align to Q1.31, take the magnitude, find its top bit.
    always_comb
    begin
        logic [31:0] x;
        unique case (in_pair.cvt)
            wsd_pkg::CVT_PCM16: x = {in_pair.slot0.sample_value[15:0], 16'd0};
            wsd_pkg::CVT_PCM24: x = {in_pair.slot0.sample_value[23:0], 8'd0};
            default:            x = in_pair.slot0.sample_value;
        endcase
        neg_next = x[31];
        mag_next = x[31] ? (~x + 32'd1) : x;
        top_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag_next[i])
                top_next = 5'(i);
        end
    end

    // Register between the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
            mag_reg  <= '0;
            top_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            pair_reg <= in_pair;
            mag_reg  <= mag_next;
            top_reg  <= top_next;
            neg_reg  <= neg_next;
        end
    end

    // Stage two: normalize, round to nearest even and assemble the word.
    always_comb
    begin
        logic [31:0] mn;
        logic [24:0] keep;
        logic [7:0]  rem;
        logic [7:0]  expo;
        logic [31:0] fbits;
        mn   = mag_reg << (5'd31 - top_reg);
        rem  = mn[7:0];
        keep = {1'b0, mn[31:8]};
        if (rem > 8'h80 || (rem == 8'h80 && keep[0]))
            keep = keep + 25'd1;
        expo = 8'd96 + {3'd0, top_reg};
        if (keep[24])
        begin
            expo = expo + 8'd1;
            keep = keep >> 1;
        end
        fbits = {neg_reg, expo, keep[22:0]};
        if (mag_reg == '0)
            fbits = '0;

        out_pair = pair_reg;
        if (pair_reg.slot0.kind == wsd_pkg::KIND_SAMPLE &&
            pair_reg.cvt != wsd_pkg::CVT_FLOAT)
            out_pair.slot0.sample_value = fbits;
    end

endmodule

// ===== rtl/wsd_out_fifo.sv =====
// Result queue of the WAV decoder: takes up to two results a cycle and hands
// out one per beat. Depends on wsd_pkg.
module wsd_out_fifo #(
    parameter int DEPTH = wsd_pkg::FIFO_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wsd_pkg::pair_t               push_pair,
    output wsd_pkg::res_t                head,
    output logic                         head_valid,
    input  logic                         head_ready,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    wsd_pkg::res_t   mem_reg [DEPTH];
    logic [IW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   n_push;
    logic            pop;

    assign n_push     = CW'(push_pair.valid[0]) + CW'(push_pair.valid[1]);
    assign head_valid = (cnt_reg != '0);
    assign pop        = head_valid && head_ready;
    assign head       = mem_reg[rp_reg];
    assign fill       = cnt_reg;

    // Storage; slot1 is only valid together with slot0.
    always_ff @(posedge clk)
    begin
        if (push_pair.valid[0])
            mem_reg[wp_reg] <= push_pair.slot0;
        if (push_pair.valid[1])
            mem_reg[wp_reg + IW'(1)] <= push_pair.slot1;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + IW'(n_push);
            rp_reg  <= rp_reg + IW'(pop);
            cnt_reg <= cnt_reg + n_push - CW'(pop);
        end
    end

endmodule

// ===== rtl/wav_stream_to_float_decoder.sv =====
// Top level of the WAV byte stream decoder; ties the parser, the float
// conversion and the result queue together. Depends on wsd_pkg.
//
// The block takes one WAV file byte per beat, one beat every cycle while
// input ready is high, and turns it into format reports, errors, float
// samples and an end marker. A result passes the parser's result register,
// the register between the two float conversion stages and the output queue
// on its way out. A byte causes at most two results; the output side gives
// one result a beat, so a stream of such bytes runs at the rate of the
// output. Input ready drops while the queue plus the results still in the
// pipeline could not take two more. There is no clearing pass after reset;
// the block accepts bytes from the first cycle.
module wav_stream_to_float_decoder #(
    parameter int FIFO_DEPTH = wsd_pkg::FIFO_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_value, channel_index, rate_hz, channel_total, sample_width,
    // data_length, status, zero fill
    output logic [151:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind
    output logic         m_tlast    // final_res
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    wsd_pkg::pair_t  parse_pair, float_pair;
    wsd_pkg::res_t   head;
    logic [CW-1:0]   fill;
    logic [CW:0]     used;
    logic            accept;

    assign accept = s_tvalid && s_tready;

    // Room check over the queue and everything still in flight.
    assign used = {1'b0, fill}
                  + (CW+1)'(parse_pair.valid[0]) + (CW+1)'(parse_pair.valid[1])
                  + (CW+1)'(float_pair.valid[0]) + (CW+1)'(float_pair.valid[1]);
    assign s_tready = (used <= (CW+1)'(FIFO_DEPTH - 2));

    wsd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .out_pair (parse_pair)
    );

    wsd_to_float u_to_float (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_pair  (parse_pair),
        .out_pair (float_pair)
    );

    wsd_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_pair  (float_pair),
        .head       (head),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .fill       (fill)
    );

    // Output beat packing.
    assign m_tdata = {5'd0, head.status, head.data_length, head.sample_width,
                      head.channel_total, head.rate_hz, head.channel_index,
                      head.sample_value};
    assign m_tuser = head.kind;
    assign m_tlast = head.final_res;

endmodule

// ===== rtl/wsd_checker.sv =====
// Port-level checks for the WAV decoder top level, bound to every instance.
// Depends on wsd_pkg and wav_stream_to_float_decoder.
module wsd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [151:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    // Nothing is offered in the cycle after reset has been applied.
    a_idle_in_reset: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // A stalled beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The end marker is always the last result of its byte.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == wsd_pkg::KIND_END |-> m_tlast)
        else $error("end marker without final flag");

    // Samples and format reports carry status ok.
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == wsd_pkg::KIND_SAMPLE || m_tuser == wsd_pkg::KIND_FORMAT)
        |-> m_tdata[146:144] == wsd_pkg::ST_OK)
        else $error("sample or report with nonzero status");

    // An error carries a nonzero status.
    a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == wsd_pkg::KIND_ERROR |-> m_tdata[146:144] != wsd_pkg::ST_OK)
        else $error("error with status ok");

endmodule

bind wav_stream_to_float_decoder wsd_checker u_wsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/wav_stream_to_float_decoder_test.sv =====
// Self-checking testbench for the WAV stream to float decoder.
// Feeds whole and broken WAV files byte by byte and checks every result.
// Depends on wsd_pkg and wav_stream_to_float_decoder.
module wav_stream_to_float_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;   // data_byte
    logic         s_tlast = 1'b0;   // end_of_stream
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // sample_value, channel_index, rate_hz, channel_total, sample_width,
    // data_length, status, zero fill
    logic [151:0] m_tdata;
    logic [1:0]   m_tuser;          // kind
    logic         m_tlast;          // final_res

    wav_stream_to_float_decoder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // Pending input beats: bit 8 is end of stream, bits 7:0 the file byte.
    logic [8:0] byte_feed_q[$];
    // File under construction.
    logic [7:0] file_bytes[$];
    // Results still owed by the block, oldest first.
    res_t       owed_results_q[$];

    int mismatch_count = 0;
    int files_sent = 0;
    int bytes_sent = 0;
    int samples_seen = 0;
    int results_seen = 0;

    // Decoder state mirrored by the predictor.
    phase_t      ph;
    logic [4:0]  unit_cnt;
    logic [31:0] tag_sr;
    logic [31:0] chunk_len;
    logic [32:0] skip_left;
    logic [15:0] fmt_code;
    logic [15:0] n_chan;
    logic [31:0] rate;
    logic [15:0] blk_align;
    logic [15:0] bits;
    logic        have_fmt;
    logic [31:0] data_left;
    logic [15:0] chan_pos;
    logic [31:0] raw_word;
    logic [1:0]  raw_idx;
    logic [2:0]  stream_st;
    logic [15:0] frame_pos;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic clear_decoder();
        ph = PH_RIFF;
        unit_cnt = '0;
        tag_sr = '0;
        chunk_len = '0;
        skip_left = '0;
        fmt_code = '0;
        n_chan = '0;
        rate = '0;
        blk_align = '0;
        bits = '0;
        have_fmt = 1'b0;
        data_left = '0;
        chan_pos = '0;
        raw_word = '0;
        raw_idx = '0;
        stream_st = ST_OK;
        frame_pos = '0;
    endtask

    // Signed integer times 2^-frac as an IEEE single, round to nearest even.
    function automatic logic [31:0] fixed_to_single(input longint v, input int frac);
        logic [63:0] mag;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] expo;
        int          p;
        int          sh;
        if (v == 0)
            return 32'd0;
        mag = (v < 0) ? -v : v;
        p = 32;
        while (p > 0 && !mag[p])
            p--;
        expo = 127 + p - frac;
        if (p > 23)
        begin
            sh = p - 23;
            rem = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            keep = mag >> sh;
            if (rem > half || (rem == half && keep[0]))
                keep++;
            if (keep == (64'd1 << 24))
            begin
                keep = keep >> 1;
                expo++;
            end
        end
        else
            keep = mag << (23 - p);
        return {v < 0, expo[7:0], keep[22:0]};
    endfunction

    function automatic logic [31:0] sample_to_single(input logic [31:0] raw);
        if (fmt_code == FMT_FLOAT)
            return raw;
        if (bits == 16)
            return fixed_to_single(longint'($signed(raw[15:0])), 15);
        if (bits == 24)
            return fixed_to_single(longint'($signed(raw[23:0])), 23);
        return fixed_to_single(longint'($signed(raw)), 31);
    endfunction

    function automatic res_t blank_result(input kind_t k);
        res_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    // Advance the mirrored decoder by one byte and queue the results it owes.
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        res_t        made[$];
        res_t        r;
        logic [3:0]  i;
        int          bps;
        logic [2:0]  st;
        logic        ok_pcm;
        logic        ok_flt;
        case (ph)
            PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID:
            begin
                tag_sr = {b, tag_sr[31:8]};
                unit_cnt++;
                if (unit_cnt >= 4)
                begin
                    unit_cnt = '0;
                    if (ph == PH_RIFF)
                    begin
                        if (tag_sr != TAG_RIFF)
                        begin
                            stream_st = ST_NOT_RIFF;
                            ph = PH_DONE;
                            r = blank_result(KIND_ERROR);
                            r.status = ST_NOT_RIFF;
                            made.push_back(r);
                        end
                        else
                            ph = PH_RSIZE;
                    end
                    else if (ph == PH_RSIZE)
                        ph = PH_WAVE;
                    else if (ph == PH_WAVE)
                    begin
                        if (tag_sr != TAG_WAVE)
                        begin
                            stream_st = ST_NOT_WAVE;
                            ph = PH_DONE;
                            r = blank_result(KIND_ERROR);
                            r.status = ST_NOT_WAVE;
                            made.push_back(r);
                        end
                        else
                            ph = PH_ID;
                    end
                    else
                        ph = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                chunk_len[unit_cnt[1:0]*8 +: 8] = b;
                unit_cnt++;
                if (unit_cnt >= 4)
                begin
                    unit_cnt = '0;
                    if (tag_sr == TAG_FMT)
                        ph = PH_FMT;
                    else if (tag_sr == TAG_DATA)
                    begin
                        // Data chunk header: report the format or fail.
                        ok_pcm = fmt_code == FMT_PCM && (bits == 16 || bits == 24 || bits == 32);
                        ok_flt = fmt_code == FMT_FLOAT && bits == 32;
                        if (!have_fmt || n_chan == 0 || rate == 0 || blk_align == 0)
                            st = ST_INCOMPLETE;
                        else if (!ok_pcm && !ok_flt)
                            st = ST_UNSUPPORTED;
                        else
                            st = ST_OK;
                        if (st != ST_OK)
                        begin
                            stream_st = st;
                            ph = PH_DONE;
                            r = blank_result(KIND_ERROR);
                            r.status = st;
                        end
                        else
                        begin
                            r = blank_result(KIND_FORMAT);
                            r.rate_hz = rate;
                            r.channel_total = n_chan;
                            r.sample_width = bits;
                            r.data_length = chunk_len;
                            data_left = chunk_len;
                            frame_pos = '0;
                            ph = (chunk_len == 0) ? PH_DONE : PH_DATA;
                        end
                        made.push_back(r);
                    end
                    else
                    begin
                        skip_left = {1'b0, chunk_len} + chunk_len[0];
                        ph = (skip_left == 0) ? PH_ID : PH_SKIP;
                    end
                end
            end
            PH_FMT:
            begin
                i = unit_cnt[3:0];
                if (i < 2)
                    fmt_code[i[0]*8 +: 8] = b;
                else if (i < 4)
                    n_chan[i[0]*8 +: 8] = b;
                else if (i < 8)
                    rate[i[1:0]*8 +: 8] = b;
                else if (i >= 12 && i < 14)
                    blk_align[i[0]*8 +: 8] = b;
                else if (i >= 14)
                    bits[i[0]*8 +: 8] = b;
                unit_cnt = i + 1;
                if (unit_cnt >= 16)
                begin
                    unit_cnt = '0;
                    have_fmt = 1'b1;
                    skip_left = ((chunk_len > 16) ? {1'b0, chunk_len - 32'd16} : 33'd0)
                                + chunk_len[0];
                    ph = (skip_left == 0) ? PH_ID : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    ph = PH_ID;
            end
            PH_DATA:
            begin
                bps = bits / 8;
                if (frame_pos == 0 && data_left < blk_align)
                    ph = PH_DONE;
                else
                begin
                    if (frame_pos == 0)
                    begin
                        chan_pos = '0;
                        raw_idx = '0;
                    end
                    // Only whole samples inside the frame are decoded.
                    if (chan_pos < n_chan && int'(frame_pos) + (bps - int'(raw_idx)) <= int'(blk_align))
                    begin
                        raw_word[raw_idx*8 +: 8] = b;
                        if (raw_idx + 1 >= bps)
                        begin
                            r = blank_result(KIND_SAMPLE);
                            r.sample_value = sample_to_single(raw_word);
                            r.channel_index = chan_pos;
                            made.push_back(r);
                            chan_pos++;
                            raw_idx = '0;
                            raw_word = '0;
                        end
                        else
                            raw_idx = raw_idx + 1;
                    end
                    frame_pos++;
                    if (frame_pos >= blk_align)
                        frame_pos = '0;
                    data_left--;
                    if (data_left == 0)
                        ph = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase

        // End of stream: truncation error if still in the headers, then the end mark.
        if (eos)
        begin
            if (ph < PH_DATA)
            begin
                st = (ph == PH_RIFF) ? ST_NOT_RIFF : ((ph == PH_WAVE) ? ST_NOT_WAVE : ST_INCOMPLETE);
                stream_st = st;
                r = blank_result(KIND_ERROR);
                r.status = st;
                made.push_back(r);
            end
            r = blank_result(KIND_END);
            r.status = stream_st;
            made.push_back(r);
            clear_decoder();
        end
        foreach (made[k])
        begin
            if (k == made.size() - 1)
                made[k].final_res = 1'b1;
            owed_results_q.push_back(made[k]);
        end
    endtask

    // File building helpers.
    task automatic put_u16(input logic [15:0] v);
        file_bytes.push_back(v[7:0]);
        file_bytes.push_back(v[15:8]);
    endtask

    task automatic put_u32(input logic [31:0] v);
        put_u16(v[15:0]);
        put_u16(v[31:16]);
    endtask

    task automatic put_riff_head();
        put_u32(TAG_RIFF);
        put_u32($urandom);
        put_u32(TAG_WAVE);
    endtask

    task automatic put_fmt(input logic [31:0] size, input logic [15:0] code,
                           input logic [15:0] ch, input logic [31:0] hz,
                           input logic [15:0] align, input logic [15:0] width);
        int extra;
        put_u32(TAG_FMT);
        put_u32(size);
        put_u16(code);
        put_u16(ch);
        put_u32(hz);
        put_u32($urandom);
        put_u16(align);
        put_u16(width);
        extra = (size > 16) ? int'(size) - 16 + size[0] : int'(size[0]);
        repeat (extra) file_bytes.push_back($urandom_range(0, 255));
    endtask

    task automatic put_junk_chunk(input int len);
        put_u32($urandom);
        put_u32(len);
        repeat (len + (len % 2)) file_bytes.push_back($urandom_range(0, 255));
    endtask

    task automatic put_data(input int declared, input int present);
        put_u32(TAG_DATA);
        put_u32(declared);
        repeat (present) file_bytes.push_back($urandom_range(0, 255));
    endtask

    // Hand the built file to the driver, marking its last byte.
    task automatic send_file();
        foreach (file_bytes[k])
            byte_feed_q.push_back({k == file_bytes.size() - 1, file_bytes[k]});
        bytes_sent += file_bytes.size();
        files_sent++;
        file_bytes.delete();
    endtask

    task automatic send_pcm_words(input logic [15:0] width, input logic [31:0] words[$]);
        int bpsz;
        bpsz = width / 8;
        put_riff_head();
        put_fmt(16, FMT_PCM, 1, 48000, bpsz, width);
        put_data(bpsz * words.size(), 0);
        foreach (words[k])
            for (int j = 0; j < bpsz; j++)
                file_bytes.push_back(words[k][j*8 +: 8]);
        send_file();
    endtask

    // Random file, mostly well-formed with random content.
    task automatic send_random_file();
        logic [15:0] code;
        logic [15:0] width;
        logic [15:0] ch;
        logic [15:0] align;
        logic [31:0] hz;
        int          dlen;
        int          present;
        int          cut;
        case ($urandom_range(0, 9))
            0, 1, 2: begin code = FMT_PCM; width = 16; end
            3, 4:    begin code = FMT_PCM; width = 24; end
            5, 6:    begin code = FMT_PCM; width = 32; end
            7, 8:    begin code = FMT_FLOAT; width = 32; end
            default: begin code = $urandom_range(0, 4); width = 8 * $urandom_range(0, 5); end
        endcase
        ch = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        align = ch * (width / 8);
        if ($urandom_range(0, 5) == 0)
            align = align + $urandom_range(1, 3);
        else if ($urandom_range(0, 10) == 0)
            align = $urandom_range(0, 5);
        hz = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom;
        if ($urandom_range(0, 19) == 0)
        begin
            // Noise, or a truncated header whose tags may be broken.
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 10)) file_bytes.push_back($urandom_range(0, 255));
            else
            begin
                put_u32($urandom_range(0, 1) ? TAG_RIFF : $urandom);
                put_u32($urandom);
                put_u32($urandom_range(0, 1) ? TAG_WAVE : $urandom);
            end
            send_file();
            return;
        end
        put_riff_head();
        if ($urandom_range(0, 3) == 0)
            put_junk_chunk($urandom_range(0, 5));
        if ($urandom_range(0, 15) != 0)
            put_fmt($urandom_range(0, 4) == 0 ? $urandom_range(12, 21) : 16,
                    code, ch, hz, align, width);
        dlen = $urandom_range(0, 40);
        present = ($urandom_range(0, 7) == 0) ? $urandom_range(0, dlen) : dlen;
        put_data(dlen, present);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) file_bytes.push_back($urandom_range(0, 255));
        // Occasionally cut the file short anywhere.
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        send_file();
    endtask

    // Driver: bursts of beats with random gaps, predictor fed on acceptance.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic       nv;
        logic [8:0] nb;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tlast <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                nv = 1'b0;
                nb = {s_tlast, s_tdata};
                if (gap_left > 0)
                    gap_left--;
                else if (byte_feed_q.size() > 0)
                begin
                    nb = byte_feed_q.pop_front();
                    nv = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_tvalid <= nv;
                s_tdata <= nb[7:0];
                s_tlast <= nb[8];
            end
        end
    end

    // Receiver: stall pattern drawn from three modes, always ready, random and mostly stalled.
    int stall_cyc = 0;
    int stall_mode = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            stall_cyc++;
            if (stall_cyc % 64 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: compare each result beat with the oldest owed result.
    always @(posedge clk)
    begin : monitor
        res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (owed_results_q.size() == 0)
                report($sformatf("unexpected result kind %0d", m_tuser));
            else
            begin
                e = owed_results_q.pop_front();
                if (e.kind == KIND_SAMPLE)
                    samples_seen++;
                if (m_tuser != e.kind)
                    report($sformatf("kind %0d, wanted %0d", m_tuser, e.kind));
                if (m_tdata[31:0] != e.sample_value)
                    report($sformatf("sample %h, wanted %h", m_tdata[31:0], e.sample_value));
                if (m_tdata[47:32] != e.channel_index)
                    report($sformatf("channel %0d, wanted %0d", m_tdata[47:32], e.channel_index));
                if (m_tdata[79:48] != e.rate_hz)
                    report($sformatf("rate %0d, wanted %0d", m_tdata[79:48], e.rate_hz));
                if (m_tdata[95:80] != e.channel_total)
                    report($sformatf("channels %0d, wanted %0d", m_tdata[95:80], e.channel_total));
                if (m_tdata[111:96] != e.sample_width)
                    report($sformatf("bits %0d, wanted %0d", m_tdata[111:96], e.sample_width));
                if (m_tdata[143:112] != e.data_length)
                    report($sformatf("data length %0d, wanted %0d", m_tdata[143:112], e.data_length));
                if (m_tdata[146:144] != e.status)
                    report($sformatf("status %0d, wanted %0d", m_tdata[146:144], e.status));
                if (m_tdata[151:147] != 5'd0)
                    report("nonzero fill bits");
                if (m_tlast != e.final_res)
                    report($sformatf("final flag %0d, wanted %0d", m_tlast, e.final_res));
            end
        end
    end

    // Stimulus, then wait for the block to drain and give the verdict.
    initial
    begin : stimulus
        logic [31:0] words[$];
        clear_decoder();

        // Tag errors and truncation inside the RIFF tag, the WAVE tag and a chunk size.
        file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58, 8'h00};
        send_file();
        file_bytes = '{8'h52, 8'h49};
        send_file();
        put_u32(TAG_RIFF); put_u32(0); put_u32(32'h45564158);
        send_file();
        put_u32(TAG_RIFF); put_u32(0); file_bytes.push_back(8'h57);
        send_file();
        put_riff_head(); put_u32(TAG_FMT); put_u16(16);
        send_file();

        // PCM extremes at every width, including rounding at 32 bits.
        words = '{32'h0000, 32'h7FFF, 32'h8000, 32'hFFFF, 32'h0001};
        send_pcm_words(16, words);
        words = '{32'h000000, 32'h7FFFFF, 32'h800000, 32'hFFFFFF};
        send_pcm_words(24, words);
        words = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h01000001,
                  32'h01000080, 32'h01000180, 32'h00FFFFFF};
        send_pcm_words(32, words);

        // Float copy, unknown odd chunk before fmt, odd block align, partial frame.
        put_riff_head(); put_junk_chunk(3);
        put_fmt(18, FMT_FLOAT, 2, 44100, 9, 32); put_data(20, 20);
        file_bytes.push_back(8'hAA);
        send_file();

        // Short fmt chunk, missing fmt, zero channels, unsupported coding, empty data.
        put_riff_head(); put_fmt(14, FMT_PCM, 1, 8000, 2, 16); put_data(4, 4);
        send_file();
        put_riff_head(); put_data(4, 4);
        send_file();
        put_riff_head(); put_fmt(16, FMT_PCM, 0, 8000, 2, 16); put_data(2, 2);
        send_file();
        put_riff_head(); put_fmt(16, FMT_PCM, 1, 8000, 1, 8); put_data(2, 2);
        send_file();
        put_riff_head(); put_fmt(16, FMT_PCM, 1, 32'hFFFFFFFF, 16'hFFFF, 16);
        put_data(0, 0);
        send_file();

        // Random part.
        while (bytes_sent < 1100)
            send_random_file();

        wait (rst_n);
        do
            @(posedge clk);
        while (byte_feed_q.size() > 0 || s_tvalid || owed_results_q.size() > 0);
        repeat (20) @(posedge clk);
        if (owed_results_q.size() > 0)
            report($sformatf("%0d results never arrived", owed_results_q.size()));

        $display("Sent %0d files in %0d bytes; checked %0d results, %0d of them samples.",
                 files_sent, bytes_sent, results_seen, samples_seen);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Reset once, at the start.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
